### src/sbo_pkg.sv
`timescale 1ns / 1ps
// sbo_pkg: widths, pair kinds and stage payload structs of the sphere/box overlap test.
// No dependencies; used by every module of the block.
package sbo_pkg;

  localparam int unsigned CoordW    = 16;
  localparam int unsigned LaneW     = CoordW - 1;
  localparam int unsigned NumAxes   = 3;
  localparam int unsigned ExtW      = NumAxes * LaneW;
  localparam int unsigned DiffW     = CoordW + 1;
  localparam int unsigned MagW      = CoordW;
  localparam int unsigned SqW       = 2 * MagW;
  localparam int unsigned SumW      = SqW + 2;
  localparam int unsigned NumStages = 5;

  typedef enum logic [1:0] {
    KIND_SS,  // sphere / sphere
    KIND_BB,  // box / box
    KIND_SB   // sphere / box, sphere in lane a
  } pair_kind_e;

  typedef struct packed {
    pair_kind_e                      kind;
    logic [NumAxes-1:0][DiffW-1:0]   diff;
    logic [NumAxes-1:0][MagW-1:0]    ext;
    logic [MagW-1:0]                 rad;
  } front_t;

  typedef struct packed {
    pair_kind_e                      kind;
    logic [NumAxes-1:0][MagW-1:0]    mag;
    logic [NumAxes-1:0][MagW-1:0]    ext;
    logic [MagW-1:0]                 rad;
  } mag_t;

  typedef struct packed {
    pair_kind_e                      kind;
    logic [NumAxes-1:0][MagW-1:0]    gap;
    logic [NumAxes-1:0]              enclosed;
    logic [MagW-1:0]                 rad;
  } gap_t;

  typedef struct packed {
    pair_kind_e                      kind;
    logic [NumAxes-1:0][SqW-1:0]     sq;
    logic [NumAxes-1:0]              enclosed;
    logic [SqW-1:0]                  rsq;
  } sq_t;

endpackage

### src/sbo_front.sv
`timescale 1ns / 1ps
// sbo_front: stage 1, pair classification, sphere-first ordering, centre deltas, extents.
// Depends on sbo_pkg.
module sbo_front (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic                         first_shape_i,
  input  logic                         second_shape_i,
  input  logic [sbo_pkg::CoordW-1:0]   first_x_i,
  input  logic [sbo_pkg::CoordW-1:0]   first_y_i,
  input  logic [sbo_pkg::CoordW-1:0]   first_z_i,
  input  logic [sbo_pkg::CoordW-1:0]   second_x_i,
  input  logic [sbo_pkg::CoordW-1:0]   second_y_i,
  input  logic [sbo_pkg::CoordW-1:0]   second_z_i,
  input  logic [sbo_pkg::ExtW-1:0]     first_extent_i,
  input  logic [sbo_pkg::ExtW-1:0]     second_extent_i,
  output sbo_pkg::front_t              front_o
);

  logic [sbo_pkg::CoordW-1:0] p1 [sbo_pkg::NumAxes];
  logic [sbo_pkg::CoordW-1:0] p2 [sbo_pkg::NumAxes];
  logic [sbo_pkg::CoordW-1:0] pa [sbo_pkg::NumAxes];
  logic [sbo_pkg::CoordW-1:0] pb [sbo_pkg::NumAxes];
  logic [sbo_pkg::LaneW-1:0]  ha [sbo_pkg::NumAxes];
  logic [sbo_pkg::LaneW-1:0]  hb [sbo_pkg::NumAxes];
  logic                       swap;
  sbo_pkg::front_t            front_d;
  sbo_pkg::front_t            front_q;

  assign p1[0] = first_x_i;
  assign p1[1] = first_y_i;
  assign p1[2] = first_z_i;
  assign p2[0] = second_x_i;
  assign p2[1] = second_y_i;
  assign p2[2] = second_z_i;

  // box first, sphere second: swap so the sphere sits in lane a
  assign swap = first_shape_i & ~second_shape_i;

  always_comb begin
    for (int i = 0; i < sbo_pkg::NumAxes; i++) begin
      pa[i] = swap ? p2[i] : p1[i];
      pb[i] = swap ? p1[i] : p2[i];
      ha[i] = swap ? second_extent_i[i*sbo_pkg::LaneW +: sbo_pkg::LaneW]
                   : first_extent_i[i*sbo_pkg::LaneW +: sbo_pkg::LaneW];
      hb[i] = swap ? first_extent_i[i*sbo_pkg::LaneW +: sbo_pkg::LaneW]
                   : second_extent_i[i*sbo_pkg::LaneW +: sbo_pkg::LaneW];
    end

    unique case ({first_shape_i, second_shape_i})
      2'b00:        front_d.kind = sbo_pkg::KIND_SS;
      2'b11:        front_d.kind = sbo_pkg::KIND_BB;
      2'b01, 2'b10: front_d.kind = sbo_pkg::KIND_SB;
    endcase

    for (int i = 0; i < sbo_pkg::NumAxes; i++) begin
      front_d.diff[i] = {pa[i][sbo_pkg::CoordW-1], pa[i]} - {pb[i][sbo_pkg::CoordW-1], pb[i]};
      unique case (front_d.kind)
        sbo_pkg::KIND_SS: front_d.ext[i] = '0;
        sbo_pkg::KIND_BB: front_d.ext[i] = {1'b0, ha[i]} + {1'b0, hb[i]};
        default:          front_d.ext[i] = {1'b0, hb[i]};
      endcase
    end

    // radius sum for two spheres, otherwise lane a's first extent (the sphere radius for sphere/box)
    if (front_d.kind == sbo_pkg::KIND_SS) begin
      front_d.rad = {1'b0, ha[0]} + {1'b0, hb[0]};
    end else begin
      front_d.rad = {1'b0, ha[0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      front_q <= front_d;
    end
  end

  assign front_o = front_q;

endmodule

### src/sbo_gap.sv
`timescale 1ns / 1ps
// sbo_gap: stages 2 and 3, per-axis distance magnitude, then gap outside the extent.
// Depends on sbo_pkg.
module sbo_gap (
  input  logic              clk_i,
  input  logic              en_mag_i,
  input  logic              en_gap_i,
  input  sbo_pkg::front_t   front_i,
  output sbo_pkg::gap_t     gap_o
);

  sbo_pkg::mag_t  mag_d;
  sbo_pkg::mag_t  mag_q;
  sbo_pkg::gap_t  gap_d;
  sbo_pkg::gap_t  gap_q;
  logic [sbo_pkg::DiffW-1:0] neg;
  logic [sbo_pkg::MagW:0]    excess [sbo_pkg::NumAxes];

  always_comb begin
    mag_d.kind = front_i.kind;
    mag_d.ext  = front_i.ext;
    mag_d.rad  = front_i.rad;
    neg        = '0;
    for (int i = 0; i < sbo_pkg::NumAxes; i++) begin
      neg = -front_i.diff[i];
      mag_d.mag[i] = front_i.diff[i][sbo_pkg::DiffW-1] ? neg[sbo_pkg::MagW-1:0]
                                                       : front_i.diff[i][sbo_pkg::MagW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_mag_i) begin
      mag_q <= mag_d;
    end
  end

  // excess < 0: strictly inside the extent; otherwise the excess is the gap
  always_comb begin
    gap_d.kind = mag_q.kind;
    gap_d.rad  = mag_q.rad;
    for (int i = 0; i < sbo_pkg::NumAxes; i++) begin
      excess[i]          = {1'b0, mag_q.mag[i]} - {1'b0, mag_q.ext[i]};
      gap_d.enclosed[i]  = excess[i][sbo_pkg::MagW];
      gap_d.gap[i]       = excess[i][sbo_pkg::MagW] ? '0 : excess[i][sbo_pkg::MagW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_gap_i) begin
      gap_q <= gap_d;
    end
  end

  assign gap_o = gap_q;

endmodule

### src/sbo_square.sv
`timescale 1ns / 1ps
// sbo_square: stage 4, squares of the three gaps and of the radius, one multiplier each.
// Depends on sbo_pkg.
module sbo_square (
  input  logic            clk_i,
  input  logic            en_i,
  input  sbo_pkg::gap_t   gap_i,
  output sbo_pkg::sq_t    sq_o
);

  sbo_pkg::sq_t sq_d;
  sbo_pkg::sq_t sq_q;

  always_comb begin
    sq_d.kind     = gap_i.kind;
    sq_d.enclosed = gap_i.enclosed;
    for (int i = 0; i < sbo_pkg::NumAxes; i++) begin
      sq_d.sq[i] = {{sbo_pkg::MagW{1'b0}}, gap_i.gap[i]} *
                   {{sbo_pkg::MagW{1'b0}}, gap_i.gap[i]};
    end
    sq_d.rsq = {{sbo_pkg::MagW{1'b0}}, gap_i.rad} * {{sbo_pkg::MagW{1'b0}}, gap_i.rad};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= sq_d;
    end
  end

  assign sq_o = sq_q;

endmodule

### src/sbo_judge.sv
`timescale 1ns / 1ps
// sbo_judge: stage 5, squared distance sum against squared radius, or all-axes box test.
// Depends on sbo_pkg; its register is the output word.
module sbo_judge (
  input  logic           clk_i,
  input  logic           en_i,
  input  sbo_pkg::sq_t   sq_i,
  output logic           overlap_o
);

  logic [sbo_pkg::SumW-1:0] dist_sq;
  logic                     overlap_d;
  logic                     overlap_q;

  always_comb begin
    dist_sq = {2'b00, sq_i.sq[0]} + {2'b00, sq_i.sq[1]} + {2'b00, sq_i.sq[2]};
    if (sq_i.kind == sbo_pkg::KIND_BB) begin
      overlap_d = &sq_i.enclosed;
    end else begin
      overlap_d = dist_sq < {2'b00, sq_i.rsq};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      overlap_q <= overlap_d;
    end
  end

  assign overlap_o = overlap_q;

endmodule

### src/sphere_box_overlap_test_unit.sv
`timescale 1ns / 1ps
// sphere_box_overlap_test_unit: top level of the sphere/box pair overlap test.
// Depends on sbo_pkg, sbo_front, sbo_gap, sbo_square, sbo_judge.
//
//   channel  handshake                  payload
//   in       in_valid_i / in_stall_o    first_/second_ shape, x, y, z, extent
//   out      out_valid_o / out_stall_i  overlap_o
//
// One pair word per cycle sustained while out_stall_i is low; register stages
// front, magnitude, gap, square, judge. Stage 4 multipliers bound the clock.
// Reset clears only the stage valid bits; payload registers are not reset.
// Each stage holds while its successor is full and held, so bubbles are
// squeezed out; in_stall_o rises only when all five stages are full and the
// output word is stalled.
module sphere_box_overlap_test_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        first_shape_i,
  input  logic                        second_shape_i,
  input  logic [sbo_pkg::CoordW-1:0]  first_x_i,
  input  logic [sbo_pkg::CoordW-1:0]  first_y_i,
  input  logic [sbo_pkg::CoordW-1:0]  first_z_i,
  input  logic [sbo_pkg::CoordW-1:0]  second_x_i,
  input  logic [sbo_pkg::CoordW-1:0]  second_y_i,
  input  logic [sbo_pkg::CoordW-1:0]  second_z_i,
  input  logic [sbo_pkg::ExtW-1:0]    first_extent_i,
  input  logic [sbo_pkg::ExtW-1:0]    second_extent_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        overlap_o
);

  // per-stage valid bits and advance enables
  logic [sbo_pkg::NumStages-1:0] vld_q;
  logic [sbo_pkg::NumStages-1:0] vld_d;
  logic [sbo_pkg::NumStages-1:0] en;

  sbo_pkg::front_t front;
  sbo_pkg::gap_t   gap;
  sbo_pkg::sq_t    sq;

  // a stage loads when it is empty or its content moves on
  always_comb begin
    en[sbo_pkg::NumStages-1] = !vld_q[sbo_pkg::NumStages-1] || !out_stall_i;
    for (int k = sbo_pkg::NumStages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (en[0]) begin
      vld_d[0] = in_valid_i;
    end
    for (int k = 1; k < sbo_pkg::NumStages; k++) begin
      if (en[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = vld_q[sbo_pkg::NumStages-1];

  sbo_front u_front (
    .clk_i           (clk_i),
    .en_i            (en[0]),
    .first_shape_i   (first_shape_i),
    .second_shape_i  (second_shape_i),
    .first_x_i       (first_x_i),
    .first_y_i       (first_y_i),
    .first_z_i       (first_z_i),
    .second_x_i      (second_x_i),
    .second_y_i      (second_y_i),
    .second_z_i      (second_z_i),
    .first_extent_i  (first_extent_i),
    .second_extent_i (second_extent_i),
    .front_o         (front)
  );

  sbo_gap u_gap (
    .clk_i    (clk_i),
    .en_mag_i (en[1]),
    .en_gap_i (en[2]),
    .front_i  (front),
    .gap_o    (gap)
  );

  sbo_square u_square (
    .clk_i (clk_i),
    .en_i  (en[3]),
    .gap_i (gap),
    .sq_o  (sq)
  );

  sbo_judge u_judge (
    .clk_i     (clk_i),
    .en_i      (en[4]),
    .sq_i      (sq),
    .overlap_o (overlap_o)
  );

endmodule

### src/sbo_checker.sv
`timescale 1ns / 1ps
// sbo_checker: port-level assertions for sphere_box_overlap_test_unit, bound below.
// Depends only on the top level's port names.
module sbo_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic overlap_o
);

  // a held output word keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(overlap_o))
    else $error("held output word changed");

  // input backpressure only when the output word is full and held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // with no output stall meanwhile, an accepted word always reaches the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(in_valid_i && !in_stall_o && rst_ni, 5) &&
    $past(rst_ni, 1) && $past(rst_ni, 2) && $past(rst_ni, 3) && $past(rst_ni, 4) &&
    !$past(out_stall_i, 1) && !$past(out_stall_i, 2) &&
    !$past(out_stall_i, 3) && !$past(out_stall_i, 4)
    |-> out_valid_o)
    else $error("pipeline lost a word");

endmodule

bind sphere_box_overlap_test_unit sbo_checker u_sbo_checker (.*);
